// ===== rtl/core/mktt_pkg.sv =====
// shared types, codes and constants for the masked key translation table
// no dependencies; used by mktt_match, masked_key_translation_table_top, mktt_checker and tb_top
package mktt_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned KeyWidth          = 16;
  localparam int unsigned ModeBitCount      = 8;
  localparam int unsigned TextHandleWidth   = 12;
  localparam int unsigned CmdWidth          = 4;
  localparam int unsigned LenWidth          = 4;
  localparam int unsigned StatusWidth       = 3;
  localparam int unsigned OpWidth           = 2;
  localparam int unsigned InDataWidth       = 72;
  localparam int unsigned OutDataWidth      = 24;

  typedef enum logic [OpWidth-1:0] {
    OP_LOOKUP   = 2'd0,
    OP_INS_MASK = 2'd1,
    OP_INS_TRI  = 2'd2
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [KeyWidth-1:0]        key;
    logic [ModeBitCount-1:0]    value;
    logic [ModeBitCount-1:0]    care;
    logic [CmdWidth-1:0]        cmd;
    logic [TextHandleWidth-1:0] text;
    logic [LenWidth-1:0]        len;
  } entry_t;

  // tristate form: bit 2b+1 is care, bit 2b is value
  function automatic logic [2*ModeBitCount-1:0] tri_unpack(
    input logic [2*ModeBitCount-1:0] pat
  );
    logic [ModeBitCount-1:0] care;
    logic [ModeBitCount-1:0] value;
    for (int b = 0; b < ModeBitCount; b++) begin
      care[b]  = pat[2*b+1];
      value[b] = pat[2*b];
    end
    return {care, value};
  endfunction

endpackage

// ===== rtl/core/mktt_match.sv =====
// ternary compare of one stored entry against a probe key, value and care mask
// depends on mktt_pkg
module mktt_match (
  input  mktt_pkg::entry_t                      entry_i,
  input  logic [mktt_pkg::KeyWidth-1:0]         key_i,
  input  logic [mktt_pkg::ModeBitCount-1:0]     value_i,
  input  logic [mktt_pkg::ModeBitCount-1:0]     care_i,
  output logic                                  hit_o
);
  import mktt_pkg::*;

  logic [ModeBitCount-1:0] both_care;

  // only bits that both sides care about take part
  assign both_care = entry_i.care & care_i;
  assign hit_o     = (entry_i.key == key_i) &&
                     ((entry_i.value & both_care) == (value_i & both_care));

endmodule

// ===== rtl/core/masked_key_translation_table_top.sv =====
// top level of the masked key translation table: entry memory, scan sequencer
// depends on mktt_pkg and mktt_match
//
//  port group  | dir | tdata (lsb first)                               | tuser
//  s_axis      | in  | key, mode, care, tristate, cmd, text, len, pad  | op
//  m_axis      | out | found cmd, found text, found len, pad            | status
//
// a lookup or insert scans the stored entries one per cycle through the single
// read port of the entry memory, stopping early on a match; the unused op code
// skips the scan and answers with a miss
// reset empties the table at once (count to zero), no clearing pass
// a new item is taken once the previous one is finished; a finished result
// waits in the output register while the next item is scanned
module masked_key_translation_table_top #(
  parameter int unsigned TABLE_DEPTH = mktt_pkg::TableDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key[15:0] mode[23:16] care[31:24] tristate[47:32] cmd[51:48] text[63:52] len[67:64]
  input  logic [mktt_pkg::InDataWidth-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [mktt_pkg::OpWidth-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cmd[3:0] text[15:4] len[19:16]
  output logic [mktt_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // status[2:0]
  output logic [mktt_pkg::StatusWidth-1:0]   m_axis_tuser
);
  import mktt_pkg::*;

  localparam int unsigned AddrWidth  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountWidth = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [CountWidth-1:0]   count_q, count_d;
  logic [CountWidth-1:0]   rd_idx_q, rd_idx_d;
  logic                    pend_q, pend_d;
  logic                    lookup_q, lookup_d;
  entry_t                  probe_q, probe_d;
  status_e                 res_st_q, res_st_d;
  entry_t                  res_q, res_d;
  logic                    m_valid_q, m_valid_d;
  logic [OutDataWidth-1:0] m_data_q, m_data_d;
  status_e                 m_user_q, m_user_d;

  entry_t                  mem [TABLE_DEPTH];
  entry_t                  rd_data_q;
  logic                    rd_en, wr_en;
  logic                    hit;

  logic [2*ModeBitCount-1:0] tri_fields;
  logic                      accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tri_fields    = tri_unpack(s_axis_tdata[47:32]);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  mktt_match u_match (
    .entry_i (rd_data_q),
    .key_i   (probe_q.key),
    .value_i (probe_q.value),
    .care_i  (probe_q.care),
    .hit_o   (hit)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    pend_d    = 1'b0;
    lookup_d  = lookup_q;
    probe_d   = probe_q;
    res_st_d  = res_st_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          probe_d.key  = s_axis_tdata[15:0];
          probe_d.cmd  = s_axis_tdata[51:48];
          probe_d.text = s_axis_tdata[63:52];
          probe_d.len  = s_axis_tdata[67:64];
          rd_idx_d     = '0;
          res_d        = '0;
          unique case (s_axis_tuser)
            OP_LOOKUP: begin
              // a lookup cares about every mode bit
              lookup_d      = 1'b1;
              probe_d.value = s_axis_tdata[23:16];
              probe_d.care  = '1;
              state_d       = S_SCAN;
            end
            OP_INS_MASK: begin
              lookup_d      = 1'b0;
              probe_d.value = s_axis_tdata[23:16];
              probe_d.care  = s_axis_tdata[31:24];
              state_d       = S_SCAN;
            end
            OP_INS_TRI: begin
              lookup_d      = 1'b0;
              probe_d.value = tri_fields[ModeBitCount-1:0];
              probe_d.care  = tri_fields[2*ModeBitCount-1:ModeBitCount];
              state_d       = S_SCAN;
            end
            default: begin
              res_st_d = ST_MISS;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (pend_q && hit) begin
          if (lookup_q) begin
            res_st_d = ST_HIT;
            res_d    = rd_data_q;
          end else begin
            res_st_d = ST_CONFLICT;
          end
          state_d = S_DONE;
        end else if (!pend_q && (rd_idx_q == count_q)) begin
          // every entry compared without a match
          priority if (lookup_q) begin
            res_st_d = ST_MISS;
          end else if (count_q == CountWidth'(TABLE_DEPTH)) begin
            res_st_d = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            count_d  = count_q + 1'b1;
            res_st_d = ST_INSERTED;
          end
          state_d = S_DONE;
        end else begin
          rd_en    = (rd_idx_q < count_q);
          pend_d   = rd_en;
          rd_idx_d = rd_en ? rd_idx_q + 1'b1 : rd_idx_q;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_st_q;
          m_data_d  = {4'b0, res_q.len, res_q.text, res_q.cmd};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lookup_q <= lookup_d;
    probe_q  <= probe_d;
    res_st_q <= res_st_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrWidth-1:0]] <= probe_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx_q[AddrWidth-1:0]];
    end
  end

endmodule

// ===== dv/mktt_checker.sv =====
// result checker for the masked key translation table: watches both stream ports,
// keeps its own copy of the table and compares every result with its prediction
// depends on mktt_pkg
module mktt_checker
  import mktt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  // key, mode, care, tristate, cmd, text, len, pad
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // op
  input  logic [OpWidth-1:0]      s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // cmd, text, len, pad
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  // status
  input  logic [StatusWidth-1:0]  m_axis_tuser,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e                    status;
    logic [CmdWidth-1:0]        cmd;
    logic [TextHandleWidth-1:0] text;
    logic [LenWidth-1:0]        len;
  } answer_t;

  entry_t      key_table [TABLE_DEPTH];
  int unsigned table_fill;
  answer_t     answers_due [$];
  int          results_seen;

  initial begin
    table_fill   = 0;
    results_seen = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // updates the table copy and returns the answer the block should give
  function automatic answer_t translate_item(input logic [OpWidth-1:0]     op,
                                             input logic [InDataWidth-1:0] d);
    answer_t                 ans;
    entry_t                  fresh;
    logic [15:0]             pat;
    logic [ModeBitCount-1:0] common;
    bit                      found;
    ans         = '{status: ST_MISS, cmd: '0, text: '0, len: '0};
    fresh.key   = d[15:0];
    fresh.value = d[23:16];
    fresh.care  = d[31:24];
    pat         = d[47:32];
    fresh.cmd   = d[51:48];
    fresh.text  = d[63:52];
    fresh.len   = d[67:64];
    found       = 1'b0;
    if (op == OP_LOOKUP) begin
      // lookup cares about every mode bit, only the entry's care limits it
      for (int i = 0; i < table_fill && !found; i++) begin
        if (key_table[i].key == fresh.key &&
            ((key_table[i].value ^ fresh.value) & key_table[i].care) == '0) begin
          found   = 1'b1;
          ans     = '{status: ST_HIT, cmd: key_table[i].cmd, text: key_table[i].text,
                      len: key_table[i].len};
        end
      end
    end else if (op == OP_INS_MASK || op == OP_INS_TRI) begin
      if (op == OP_INS_TRI) begin
        for (int b = 0; b < ModeBitCount; b++) begin
          fresh.care[b]  = pat[2*b+1];
          fresh.value[b] = pat[2*b];
        end
      end
      // conflict is checked before fullness
      for (int i = 0; i < table_fill && !found; i++) begin
        common = key_table[i].care & fresh.care;
        if (key_table[i].key == fresh.key &&
            ((key_table[i].value ^ fresh.value) & common) == '0) begin
          found = 1'b1;
        end
      end
      if (found) begin
        ans.status = ST_CONFLICT;
      end else if (table_fill >= TABLE_DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        key_table[table_fill] = fresh;
        table_fill++;
        ans.status = ST_INSERTED;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t due;
    answer_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: status_e'(m_axis_tuser), cmd: m_axis_tdata[3:0],
                text: m_axis_tdata[15:4], len: m_axis_tdata[19:16]};
        if (answers_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected result %0d: status %0d cmd %h text %h len %h",
                     results_seen, m_axis_tuser, got.cmd, got.text, got.len);
          end
        end else begin
          due = answers_due.pop_front();
          if (m_axis_tuser != due.status || got.cmd != due.cmd ||
              got.text != due.text || got.len != due.len) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch on result %0d: expected status %0d cmd %h text %h len %h",
                       results_seen, due.status, due.cmd, due.text, due.len);
              $display("                        got status %0d cmd %h text %h len %h",
                       m_axis_tuser, got.cmd, got.text, got.len);
            end
          end
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        answers_due.push_back(translate_item(s_axis_tuser, s_axis_tdata));
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the masked key translation table: clock, reset, stimulus
// and verdict; depends on mktt_pkg, mktt_checker and masked_key_translation_table_top
module tb_top import mktt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpWidth-1:0] OpUnused = 2'd3;
  localparam int RandomItems = 1600;
  localparam int DrainCycles = 200;
  localparam int CycleLimit  = 1000000;
  localparam int RecallDepth = 32;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic [OpWidth-1:0]      s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [StatusWidth-1:0]  m_axis_tuser;
  int                      fail_count;
  int                      pending;

  bit                      sender_calm;
  bit                      receiver_calm;
  int unsigned             results_taken;
  int unsigned             results_served;
  int unsigned             stall_left;
  logic [15:0]             recent_keys [$];
  logic [7:0]              recent_modes [$];

  masked_key_translation_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mktt_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver: after each result taken, back-pressure for a random number of cycles
  initial begin
    results_taken  = 0;
    results_served = 0;
    stall_left     = 0;
    receiver_calm  = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_taken <= results_taken + 1;
  end

  always @(negedge clk_i) begin
    int unsigned stall;
    stall = stall_left;
    if (results_served != results_taken) begin
      results_served = results_taken;
      if (results_served % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : $urandom_range(0, 15);
    end
    if (stall != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [OpWidth-1:0] op, input logic [15:0] key,
                           input logic [7:0] mode, input logic [7:0] care,
                           input logic [15:0] pat, input logic [3:0] cmd,
                           input logic [11:0] text, input logic [3:0] len);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, len, text, cmd, pat, care, mode, key};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OP_INS_MASK) begin
      recent_keys.push_back(key);
      recent_modes.push_back(mode);
      if (recent_keys.size() > RecallDepth) begin
        void'(recent_keys.pop_front());
        void'(recent_modes.pop_front());
      end
    end
  endtask

  // a few keys shared by most items so that conflicts and hits are frequent
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 15))
      0, 7:    return 16'h0000;
      1, 8:    return 16'hffff;
      2, 9:    return 16'h1234;
      3, 10:   return 16'h8001;
      4, 11:   return 16'h00ff;
      5, 12:   return 16'h7ffe;
      6, 13:   return 16'ha5c3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [OpWidth-1:0] op;
    logic [15:0]        key;
    logic [7:0]         mode;
    logic [7:0]         care;
    int                 pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    sender_calm   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, unused op code, field extremes
    send_item(OP_LOOKUP,   16'h0000, 8'h00, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OpUnused,    16'hffff, 8'hff, 8'hff, 16'hffff, 4'hf, 12'hfff, 4'hf);
    send_item(OP_INS_MASK, 16'hffff, 8'hff, 8'hff, 16'hffff, 4'hf, 12'hfff, 4'hf);
    send_item(OP_INS_MASK, 16'h0000, 8'h00, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'hffff, 8'hff, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'hffff, 8'h7f, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'h0000, 8'ha5, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    // entry with no care bits agrees with anything on the same key
    send_item(OP_INS_MASK, 16'h0000, 8'h55, 8'hff, 16'h0000, 4'h3, 12'h123, 4'h2);
    // tristate: all care value zero, all care value one, no care
    send_item(OP_INS_TRI,  16'h1234, 8'h00, 8'h00, 16'haaaa, 4'h1, 12'h111, 4'h1);
    send_item(OP_INS_TRI,  16'h1234, 8'h00, 8'h00, 16'hffff, 4'h2, 12'h222, 4'h2);
    send_item(OP_INS_TRI,  16'h1234, 8'hff, 8'hff, 16'h5555, 4'h3, 12'h333, 4'h3);
    send_item(OP_LOOKUP,   16'h1234, 8'h00, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'h1234, 8'hff, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'h1234, 8'h0f, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    // value bits outside care are stored but never matched
    send_item(OP_INS_MASK, 16'h00ff, 8'hf0, 8'h0f, 16'h0000, 4'h9, 12'h800, 4'h8);
    send_item(OP_LOOKUP,   16'h00ff, 8'h00, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    send_item(OP_LOOKUP,   16'h00ff, 8'hf1, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);
    // partial overlap: disjoint care agrees, overlapping care that differs does not
    send_item(OP_INS_MASK, 16'h00ff, 8'hf0, 8'hf0, 16'h0000, 4'h5, 12'h0a5, 4'h5);
    send_item(OP_INS_TRI,  16'h00ff, 8'h00, 8'h00, 16'h0003, 4'h6, 12'h5a0, 4'h6);
    send_item(OP_LOOKUP,   16'h00ff, 8'h01, 8'h00, 16'h0000, 4'h0, 12'h000, 4'h0);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55)      op = OP_LOOKUP;
      else if (pick < 75) op = OP_INS_MASK;
      else if (pick < 95) op = OP_INS_TRI;
      else                op = OpUnused;
      key  = pick_key();
      mode = 8'($urandom);
      care = 8'($urandom);
      if ($urandom_range(0, 1) == 0) care = care & 8'($urandom);
      if (op == OP_LOOKUP && recent_keys.size() != 0 && $urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, recent_keys.size() - 1);
        key  = recent_keys[pick];
        mode = recent_modes[pick] ^ (8'($urandom) & 8'($urandom) & 8'($urandom));
      end
      send_item(op, key, mode, care, 16'($urandom), 4'($urandom), 12'($urandom),
                4'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
